// ===== rtl/core/wafm_pkg.sv =====
// Shared types and constants of the wireless attack frame monitor.
package wafm_pkg;

    // Input operation and frame kind codes.
    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic KIND_MGMT = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Alert codes.
    localparam logic [1:0] ALERT_DEAUTH = 2'd0;
    localparam logic [1:0] ALERT_PROBE  = 2'd1;
    localparam logic [1:0] ALERT_DUP_IP = 2'd2;
    localparam logic [1:0] ALERT_SPOOF  = 2'd3;

    // Management subtypes, taken from the high nibble of the first byte.
    localparam logic [3:0] SUB_DEAUTH   = 4'hC;
    localparam logic [3:0] SUB_DISASSOC = 4'hA;
    localparam logic [3:0] SUB_PROBE    = 4'h4;

    // ARP EtherType bytes and the reply opcode.
    localparam logic [7:0]  ETH_HI   = 8'h08;
    localparam logic [7:0]  ETH_LO   = 8'h06;
    localparam logic [15:0] OP_REPLY = 16'h0002;

    // Byte offsets inside the ARP packet, counted from the EtherType.
    localparam logic [4:0] ARP_START     = 5'd2;
    localparam logic [4:0] ARP_OP_FIRST  = 5'd8;
    localparam logic [4:0] ARP_OP_LAST   = 5'd9;
    localparam logic [4:0] ARP_SMAC_FIRST = 5'd10;
    localparam logic [4:0] ARP_SMAC_LAST = 5'd15;
    localparam logic [4:0] ARP_SIP_FIRST = 5'd16;
    localparam logic [4:0] ARP_SIP_LAST  = 5'd19;
    localparam logic [4:0] ARP_TIP_FIRST = 5'd26;
    localparam logic [4:0] ARP_TIP_LAST  = 5'd29;

    // Saturation value of a reported count.
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_DEAUTH_THR = 3'd0;
    localparam logic [2:0] REG_PROBE_THR  = 3'd1;
    localparam logic [2:0] REG_GW_KNOWN   = 3'd2;
    localparam logic [2:0] REG_GW_MAC     = 3'd3;
    localparam logic [2:0] REG_GW_IP      = 3'd4;
    localparam logic [2:0] REG_OWN_IP     = 3'd5;
    localparam logic [2:0] REG_OWN_MAC    = 3'd6;

    // Reset values of the thresholds.
    localparam logic [15:0] DEAUTH_THR_RESET = 16'd5;
    localparam logic [15:0] PROBE_THR_RESET  = 16'd50;

    // Depth of the event queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration as seen by the front.
    typedef struct packed {
        logic [15:0] deauth_thr;
        logic [15:0] probe_thr;
        logic        gw_known;
        logic [47:0] gw_mac;
        logic [31:0] gw_ip;
        logic [31:0] own_ip;
        logic [47:0] own_mac;
    } t_cfg;

    // One queued event: one or two alerts caused by a single input item.
    typedef struct packed {
        logic        second;
        logic [1:0]  code0;
        logic [15:0] count0;
        logic [1:0]  code1;
        logic [15:0] count1;
        logic [31:0] address;
    } t_event;

endpackage

// ===== rtl/core/wafm_front.sv =====
// Front part: accepts frame bytes and ticks, parses frames and builds alert events.
module wafm_front
    import wafm_pkg::*;
#(
    parameter int COUNT_WIDTH     = 16,
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_operation,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_event     o_event
);

    localparam int IW    = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // ARP parser phases.
    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [COUNT_WIDTH-1:0] r_deauth, n_deauth;
    logic [COUNT_WIDTH-1:0] r_disassoc, n_disassoc;
    logic [COUNT_WIDTH-1:0] r_probe, n_probe;
    logic [IW-1:0]          r_index, n_index;
    logic                   r_prev8, n_prev8;
    logic [1:0]             r_phase, n_phase;
    logic [4:0]             r_offset, n_offset;
    logic [15:0]            r_opcode, n_opcode;
    logic [47:0]            r_smac, n_smac;
    logic [31:0]            r_sip, n_sip;
    logic [31:0]            r_tip, n_tip;

    logic                   accept;
    logic                   hit_a, hit_b;
    logic [1:0]             code_a, code_b;
    logic [15:0]            cnt_a, cnt_b;
    logic [31:0]            addr;
    logic [CMP_W-1:0]       deauth_ext, disassoc_ext, probe_ext, max_ext;
    logic                   arp_enable;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign deauth_ext   = CMP_W'(r_deauth);
    assign disassoc_ext = CMP_W'(r_disassoc);
    assign probe_ext    = CMP_W'(r_probe);
    assign max_ext      = (deauth_ext > disassoc_ext) ? deauth_ext : disassoc_ext;
    assign arp_enable   = i_cfg.gw_known && (i_cfg.gw_mac[47:40] != 8'h00);

    // Parse one accepted item and work out the alerts it causes.
    always_comb begin
        n_deauth   = r_deauth;
        n_disassoc = r_disassoc;
        n_probe    = r_probe;
        n_index    = r_index;
        n_prev8    = r_prev8;
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_opcode   = r_opcode;
        n_smac     = r_smac;
        n_sip      = r_sip;
        n_tip      = r_tip;
        hit_a      = 1'b0;
        hit_b      = 1'b0;
        code_a     = ALERT_DEAUTH;
        code_b     = ALERT_PROBE;
        cnt_a      = 16'd0;
        cnt_b      = 16'd0;
        addr       = 32'd0;
        if (accept) begin
            if (i_operation == OP_TICK) begin
                // End of a counting window: compare, report and clear.
                hit_a  = (deauth_ext > CMP_W'(i_cfg.deauth_thr)) ||
                         (disassoc_ext > CMP_W'(i_cfg.deauth_thr));
                hit_b  = probe_ext > CMP_W'(i_cfg.probe_thr);
                code_a = ALERT_DEAUTH;
                code_b = ALERT_PROBE;
                cnt_a  = (max_ext > CMP_W'(COUNT_SAT)) ? COUNT_SAT : max_ext[15:0];
                cnt_b  = (probe_ext > CMP_W'(COUNT_SAT)) ? COUNT_SAT : probe_ext[15:0];
                n_deauth   = '0;
                n_disassoc = '0;
                n_probe    = '0;
            end else begin
                if (i_first) begin
                    n_index  = '0;
                    n_prev8  = 1'b0;
                    n_phase  = PH_SEARCH;
                    n_offset = 5'd0;
                end
                if (n_index < IW'(MAX_FRAME_BYTES)) begin
                    if (i_kind == KIND_MGMT) begin
                        // Only the first byte of a management frame carries the subtype.
                        n_prev8 = 1'b0;
                        if (n_index == '0) begin
                            case (i_byte[7:4])
                                SUB_DEAUTH: begin
                                    if (r_deauth != '1) n_deauth = r_deauth + 1'b1;
                                end
                                SUB_DISASSOC: begin
                                    if (r_disassoc != '1) n_disassoc = r_disassoc + 1'b1;
                                end
                                SUB_PROBE: begin
                                    if (r_probe != '1) n_probe = r_probe + 1'b1;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end else if (n_phase == PH_SEARCH) begin
                        // Look for the ARP EtherType pair.
                        if (n_prev8 && (i_byte == ETH_LO)) begin
                            n_phase  = PH_CAPTURE;
                            n_offset = ARP_START;
                            n_prev8  = 1'b0;
                        end else begin
                            n_prev8 = (i_byte == ETH_HI);
                        end
                    end else if (n_phase == PH_CAPTURE) begin
                        // Capture the ARP fields by offset.
                        if (n_offset >= ARP_OP_FIRST && n_offset <= ARP_OP_LAST) begin
                            n_opcode = {r_opcode[7:0], i_byte};
                        end else if (n_offset >= ARP_SMAC_FIRST && n_offset <= ARP_SMAC_LAST) begin
                            n_smac = {r_smac[39:0], i_byte};
                        end else if (n_offset >= ARP_SIP_FIRST && n_offset <= ARP_SIP_LAST) begin
                            n_sip = {r_sip[23:0], i_byte};
                        end else if (n_offset >= ARP_TIP_FIRST && n_offset <= ARP_TIP_LAST) begin
                            n_tip = {r_tip[23:0], i_byte};
                        end
                        if (n_offset >= ARP_TIP_LAST) begin
                            n_phase = PH_DONE;
                            if (arp_enable) begin
                                hit_a = (n_opcode == OP_REPLY) && (n_tip == i_cfg.own_ip) &&
                                        (n_smac != i_cfg.own_mac);
                                hit_b = (n_sip == i_cfg.gw_ip) && (n_smac != i_cfg.gw_mac);
                            end
                            code_a = ALERT_DUP_IP;
                            code_b = ALERT_SPOOF;
                            addr   = n_sip;
                        end else begin
                            n_offset = n_offset + 5'd1;
                        end
                    end
                    n_index = n_index + 1'b1;
                end
                if (i_last) begin
                    n_index  = '0;
                    n_prev8  = 1'b0;
                    n_phase  = PH_SEARCH;
                    n_offset = 5'd0;
                end
            end
        end
    end

    // Pack the alerts of this item into one queue entry.
    always_comb begin
        o_event        = '0;
        o_event.address = addr;
        if (hit_a) begin
            o_event.code0  = code_a;
            o_event.count0 = cnt_a;
            o_event.second = hit_b;
            o_event.code1  = code_b;
            o_event.count1 = cnt_b;
        end else begin
            o_event.code0  = code_b;
            o_event.count0 = cnt_b;
        end
    end

    assign o_push = hit_a || hit_b;

    // Parser and counter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deauth   <= '0;
            r_disassoc <= '0;
            r_probe    <= '0;
            r_index    <= '0;
            r_prev8    <= 1'b0;
            r_phase    <= PH_SEARCH;
            r_offset   <= 5'd0;
            r_opcode   <= 16'd0;
            r_smac     <= 48'd0;
            r_sip      <= 32'd0;
            r_tip      <= 32'd0;
        end else begin
            r_deauth   <= n_deauth;
            r_disassoc <= n_disassoc;
            r_probe    <= n_probe;
            r_index    <= n_index;
            r_prev8    <= n_prev8;
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_opcode   <= n_opcode;
            r_smac     <= n_smac;
            r_sip      <= n_sip;
            r_tip      <= n_tip;
        end
    end

endmodule

// ===== rtl/core/wafm_queue.sv =====
// Short event queue between the front and the back.
module wafm_queue
    import wafm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_event o_data,
    output logic   o_empty
);

    t_event              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/wafm_back.sv =====
// Back part: turns queued events into one or two alert transfers.
module wafm_back
    import wafm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_event      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_code,
    output logic [15:0] o_count,
    output logic [31:0] o_address,
    output logic        o_last
);

    logic        r_valid;
    logic        r_pend;
    logic [1:0]  r_code;
    logic [15:0] r_count;
    logic [31:0] r_address;
    logic        r_last;
    logic [1:0]  r_p_code;
    logic [15:0] r_p_count;
    logic        out_free;

    assign out_free  = !r_valid || i_ready;
    assign o_pop     = out_free && !r_pend && !i_empty;
    assign o_valid   = r_valid;
    assign o_code    = r_code;
    assign o_count   = r_count;
    assign o_address = r_address;
    assign o_last    = r_last;

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_head.second;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload; the second alert of a pair keeps the address of the first.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_code  <= r_p_code;
                r_count <= r_p_count;
                r_last  <= 1'b1;
            end else if (!i_empty) begin
                r_code    <= i_head.code0;
                r_count   <= i_head.count0;
                r_address <= i_head.address;
                r_last    <= !i_head.second;
                r_p_code  <= i_head.code1;
                r_p_count <= i_head.count1;
            end
        end
    end

endmodule

// ===== rtl/core/wifi_attack_frame_monitor.sv =====
// Top level of the wireless attack frame monitor: configuration port, front, queue and back.
//
//  Channel   Direction  Transfer when               Contents
//  s_axis    in         s_axis_tvalid & tready      frame byte or interval tick
//  m_axis    out        m_axis_tvalid & tready      one alert
//  APB       in/out     psel & penable & pwrite     register write, 64-bit data
//
// One input item is accepted per cycle while the event queue is not full; an item
// raising two alerts gives two output transfers, and the back pops no further event
// until the second is loaded. A four-entry event queue separates parsing from output,
// and s_axis_tready drops only while it is full. Reset is synchronous; no clearing pass follows it.
// An alert goes from its queue entry to the output register of the back once the output is free.
module wifi_attack_frame_monitor
    import wafm_pkg::*;
#(
    parameter int COUNT_WIDTH     = 16,
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic [2:0]  s_axis_tuser,   // [0] operation, [1] frame_kind, [2] first_of_frame
    input  logic        s_axis_tlast,   // last_of_frame
    // Alert stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] alert_count, [47:16] alert_address
    output logic [1:0]  m_axis_tuser,   // [1:0] alert_code
    output logic        m_axis_tlast,   // last_alert
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [15:0] r_deauth_thr;
    logic [15:0] r_probe_thr;
    logic        r_gw_known;
    logic [47:0] r_gw_mac;
    logic [31:0] r_gw_ip;
    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;

    t_cfg        cfg;
    t_event      push_event;
    t_event      head_event;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic [1:0]  out_code;
    logic [15:0] out_count;
    logic [31:0] out_address;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[5:3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deauth_thr <= DEAUTH_THR_RESET;
            r_probe_thr  <= PROBE_THR_RESET;
            r_gw_known   <= 1'b0;
            r_gw_mac     <= 48'd0;
            r_gw_ip      <= 32'd0;
            r_own_ip     <= 32'd0;
            r_own_mac    <= 48'd0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_DEAUTH_THR: r_deauth_thr <= pwdata[15:0];
                REG_PROBE_THR:  r_probe_thr  <= pwdata[15:0];
                REG_GW_KNOWN:   r_gw_known   <= pwdata[0];
                REG_GW_MAC:     r_gw_mac     <= pwdata[47:0];
                REG_GW_IP:      r_gw_ip      <= pwdata[31:0];
                REG_OWN_IP:     r_own_ip     <= pwdata[31:0];
                REG_OWN_MAC:    r_own_mac    <= pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_index)
            REG_DEAUTH_THR: prdata = 64'(r_deauth_thr);
            REG_PROBE_THR:  prdata = 64'(r_probe_thr);
            REG_GW_KNOWN:   prdata = 64'(r_gw_known);
            REG_GW_MAC:     prdata = 64'(r_gw_mac);
            REG_GW_IP:      prdata = 64'(r_gw_ip);
            REG_OWN_IP:     prdata = 64'(r_own_ip);
            REG_OWN_MAC:    prdata = 64'(r_own_mac);
            default:        prdata = 64'd0;
        endcase
    end

    assign cfg.deauth_thr = r_deauth_thr;
    assign cfg.probe_thr  = r_probe_thr;
    assign cfg.gw_known   = r_gw_known;
    assign cfg.gw_mac     = r_gw_mac;
    assign cfg.gw_ip      = r_gw_ip;
    assign cfg.own_ip     = r_own_ip;
    assign cfg.own_mac    = r_own_mac;

    // Front: parsing and counting.
    wafm_front #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_operation (s_axis_tuser[0]),
        .i_kind      (s_axis_tuser[1]),
        .i_byte      (s_axis_tdata),
        .i_first     (s_axis_tuser[2]),
        .i_last      (s_axis_tlast),
        .i_cfg       (cfg),
        .i_full      (full),
        .o_push      (push),
        .o_event     (push_event)
    );

    // Event queue.
    wafm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_event),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_event),
        .o_empty (empty)
    );

    // Back: alert output.
    wafm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_head    (head_event),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_code    (out_code),
        .o_count   (out_count),
        .o_address (out_address),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_code;
    assign m_axis_tdata = {out_address, out_count};

    // The front never writes into a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !full)
        else $error("event written into a full queue");

    // The first alert of a pair is followed at once by the closing alert.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("second alert of a pair not presented");

    // ARP alerts carry no count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ALERT_DUP_IP || m_axis_tuser == ALERT_SPOOF))
        |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("ARP alert with nonzero count");

endmodule
